@@ rtl/rlt_pkg.sv @@
`default_nettype none

package rlt_pkg;

  // Widths of the request and response fields.
  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int NEST_W   = 16;
  localparam int TOTAL_W  = 32;
  localparam int NOTIFY_W = 32;

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_TRY          = 3'd0,
    MODE_RELEASE      = 3'd1,
    MODE_QUERY        = 3'd2,
    MODE_NOTIFY       = 3'd3,
    MODE_RELEASE_WRLD = 3'd4,
    MODE_RELEASE_PROC = 3'd5
  } mode_t;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BUSY      = 2'd1,
    STATUS_NOT_OWNER = 2'd2
  } status_t;

endpackage

`default_nettype wire

@@ rtl/rlt_req_if.sv @@
`default_nettype none

interface rlt_req_if
  import rlt_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [INDEX_W-1:0]   lock_index;
  logic [ID_W-1:0]      world_id;
  logic [ID_W-1:0]      process_id;

  modport source (output valid, mode, lock_index, world_id, process_id, input ready);
  modport sink   (input valid, mode, lock_index, world_id, process_id, output ready);
endinterface

`default_nettype wire

@@ rtl/rlt_rsp_if.sv @@
`default_nettype none

interface rlt_rsp_if
  import rlt_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [NEST_W-1:0]    nest_count;
  logic [TOTAL_W-1:0]   total_taken;
  logic                 freed;

  modport source (output valid, status, nest_count, total_taken, freed, input ready);
  modport sink   (input valid, status, nest_count, total_taken, freed, output ready);
endinterface

`default_nettype wire

@@ rtl/rlt_ram.sv @@
`default_nettype none

module rlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/recursive_lock_table.sv @@
// Single-entry requests: the lock table memory entry is read on acceptance; the execute
// step then writes it back and loads the result register once that is free; the next request
// is taken after that. Release-all requests walk every entry, one memory read a cycle,
// freeing those held by the key, then read the addressed entry and execute as above.
// Reset: a clearing pass writes zero to every entry, with in_req.ready low throughout.
// The result register frees the table to accept the next request while a result waits.
`default_nettype none

module recursive_lock_table
  import rlt_pkg::*;
#(
  parameter int LOCKS      = 64,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rlt_req_if.sink   in_req,
  rlt_rsp_if.source out_rsp
);

  localparam int AW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
  localparam int CW = $clog2(LOCKS + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [ID_BITS-1:0]    world;
    logic [ID_BITS-1:0]    process;
    logic [COUNT_BITS-1:0] nest;
    logic [TOTAL_W-1:0]    acq;
    logic [NOTIFY_W-1:0]   notif;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       walk_r, walk_nxt;
  logic                pv_r, pv_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic                freed_r, freed_nxt;

  mode_t               req_mode_r;
  logic [INDEX_W-1:0]  req_idx_r;
  logic [ID_BITS-1:0]  req_wid_r;
  logic [ID_BITS-1:0]  req_pid_r;

  logic                out_valid_r;
  status_t             out_status_r, out_status_nxt;
  logic [NEST_W-1:0]   out_nest_r, out_nest_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic                out_freed_r, out_freed_nxt;
  logic                out_load;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata, ent_rd, ent_new;
  logic [$bits(entry_t)-1:0] ram_rdata;

  logic [AW+INDEX_W-1:0] in_idx_ext, req_idx_ext;
  logic                in_accept, out_free, req_valid, req_bulk;
  logic                held, mine, walk_match;

  rlt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (LOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent_rd = ram_rdata;

  // Handshake and request decode.
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_accept    = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign in_idx_ext   = (AW + INDEX_W)'(in_req.lock_index);
  assign req_idx_ext  = (AW + INDEX_W)'(req_idx_r);
  assign req_valid    = 32'(req_idx_r) < 32'(LOCKS);
  assign req_bulk     = (req_mode_r == MODE_RELEASE_WRLD) || (req_mode_r == MODE_RELEASE_PROC);
  assign held         = ent_rd.world != '0;
  assign mine         = held && (ent_rd.process == req_pid_r);
  assign walk_match   = (req_mode_r == MODE_RELEASE_WRLD) ? (ent_rd.world == req_wid_r)
                                                          : (ent_rd.process == req_pid_r);

  // Sequencer: clearing pass, request read, bulk walk and read-modify-write.
  always_comb begin
    state_nxt      = state_r;
    walk_nxt       = walk_r;
    pv_nxt         = 1'b0;
    wa_nxt         = wa_r;
    freed_nxt      = freed_r;
    ram_we         = 1'b0;
    ram_waddr      = wa_r;
    ram_wdata      = ent_rd;
    ram_re         = 1'b0;
    ram_raddr      = req_idx_ext[AW-1:0];
    ent_new        = ent_rd;
    out_load       = 1'b0;
    out_status_nxt = STATUS_OK;
    out_nest_nxt   = '0;
    out_total_nxt  = '0;
    out_freed_nxt  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = walk_r[AW-1:0];
        ram_wdata = '0;
        if (walk_r == CW'(LOCKS - 1)) begin
          state_nxt = ST_IDLE;
          walk_nxt  = '0;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end
      ST_IDLE: begin
        ram_raddr = in_idx_ext[AW-1:0];
        if (in_accept) begin
          ram_re = 1'b1;
          if (in_req.mode == MODE_RELEASE_WRLD || in_req.mode == MODE_RELEASE_PROC) begin
            state_nxt = ST_WALK;
            walk_nxt  = '0;
            freed_nxt = 1'b0;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_WALK: begin
        // Free the entry read last cycle if it is held by the key.
        if (pv_r && held && walk_match) begin
          ram_we            = 1'b1;
          ram_waddr         = wa_r;
          ram_wdata         = ent_rd;
          ram_wdata.world   = '0;
          ram_wdata.process = '0;
          ram_wdata.nest    = '0;
          freed_nxt         = 1'b1;
        end
        if (walk_r < CW'(LOCKS)) begin
          ram_re    = 1'b1;
          ram_raddr = walk_r[AW-1:0];
          wa_nxt    = walk_r[AW-1:0];
          walk_nxt  = walk_r + 1'b1;
          pv_nxt    = 1'b1;
        end else if (!pv_r) begin
          // Walk done: read the addressed entry for the result.
          ram_re    = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (req_bulk) begin
            out_freed_nxt = freed_r;
            if (req_valid) begin
              out_nest_nxt  = NEST_W'(ent_rd.nest);
              out_total_nxt = ent_rd.acq;
            end else begin
              out_status_nxt = STATUS_BUSY;
            end
          end else if (!req_valid) begin
            out_status_nxt = STATUS_BUSY;
          end else begin
            case (req_mode_r)
              MODE_TRY: begin
                if (held) begin
                  if (!mine || ent_rd.nest == CNT_MAX) begin
                    out_status_nxt = STATUS_BUSY;
                  end else begin
                    ent_new.nest = ent_rd.nest + 1'b1;
                    ent_new.acq  = ent_rd.acq + 1'b1;
                  end
                end else if (req_wid_r == '0) begin
                  out_status_nxt = STATUS_BUSY;
                end else begin
                  ent_new.world   = req_wid_r;
                  ent_new.process = req_pid_r;
                  ent_new.nest    = COUNT_BITS'(1);
                  ent_new.acq     = ent_rd.acq + 1'b1;
                end
              end
              MODE_RELEASE: begin
                if (!mine) begin
                  out_status_nxt = STATUS_NOT_OWNER;
                end else begin
                  if (ent_rd.nest != '0) begin
                    ent_new.nest = ent_rd.nest - 1'b1;
                  end
                  if (ent_new.nest == '0) begin
                    ent_new.world   = '0;
                    ent_new.process = '0;
                    out_freed_nxt   = 1'b1;
                  end
                end
              end
              MODE_NOTIFY: begin
                if (!mine) begin
                  out_status_nxt = STATUS_NOT_OWNER;
                end else begin
                  ent_new.notif = ent_rd.notif + 1'b1;
                end
              end
              default: begin
              end
            endcase
            ram_we    = 1'b1;
            ram_waddr = req_idx_ext[AW-1:0];
            ram_wdata = ent_new;
            if (req_mode_r == MODE_QUERY) begin
              if (ent_rd.world == req_wid_r && ent_rd.process == req_pid_r) begin
                out_nest_nxt = NEST_W'(ent_rd.nest);
              end
            end else begin
              out_nest_nxt = NEST_W'(ent_new.nest);
            end
            out_total_nxt = ent_new.acq;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_r      <= '0;
      pv_r        <= 1'b0;
      freed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      walk_r  <= walk_nxt;
      pv_r    <= pv_nxt;
      freed_r <= freed_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    wa_r <= wa_nxt;
    if (in_accept) begin
      req_mode_r <= mode_t'(in_req.mode);
      req_idx_r  <= in_req.lock_index;
      req_wid_r  <= ID_BITS'(in_req.world_id);
      req_pid_r  <= ID_BITS'(in_req.process_id);
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_nest_r   <= out_nest_nxt;
      out_total_r  <= out_total_nxt;
      out_freed_r  <= out_freed_nxt;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.nest_count  = out_nest_r;
  assign out_rsp.total_taken = out_total_r;
  assign out_rsp.freed       = out_freed_r;

  // An accepted request goes straight to execution or to the bulk walk.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_EXEC || state_r == ST_WALK))
    else $error("accepted request did not start execution");

  // A result is produced only by the execute step.
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result appeared outside the execute step");

  // The bulk walk only ever frees entries.
  a_walk_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && ram_we) |-> (ram_wdata.world == '0 && ram_wdata.nest == '0))
    else $error("bulk walk wrote a held entry");

  // The clearing pass writes zero every cycle and never accepts a request.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (ram_we && ram_wdata == '0 && !in_accept))
    else $error("clearing pass misbehaved");

  // The execute step never overwrites a waiting result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp.ready) |=> $stable(out_total_r) && $stable(out_status_r))
    else $error("waiting result was overwritten");

endmodule

`default_nettype wire
